// ===== hw/rtl/hte_pkg.sv =====
// ----------------------------------------------------------------------------
// hte_pkg
// Request codes and the classified item type shared by the front and back
// halves of the transform engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hte_pkg;

  localparam logic [2:0] REQ_LOAD      = 3'd0;
  localparam logic [2:0] REQ_APPEND    = 3'd1;
  localparam logic [2:0] REQ_HOMOG     = 3'd2;
  localparam logic [2:0] REQ_POSITION  = 3'd3;
  localparam logic [2:0] REQ_VECTOR    = 3'd4;
  localparam logic [2:0] REQ_TRANSPOSE = 3'd5;
  localparam logic [2:0] REQ_INVERSE   = 3'd6;
  localparam logic [2:0] REQ_UNUSED    = 3'd7;

  localparam int unsigned WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [1:0]       col;
    logic [3:0][31:0] vec;
  } hte_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hte_front.sv =====
// ----------------------------------------------------------------------------
// hte_front
// Accepts request beats, fills in w for position and vector requests, drops
// the unused code and queues items in a two-entry FIFO for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hte_front #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [2:0]        in_req_type,
  input  wire logic [1:0]        in_column_index,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_y,
  input  wire logic signed [31:0] in_z,
  input  wire logic signed [31:0] in_w,
  output      logic              q_valid,
  output      hte_pkg::hte_item_t q_item,
  input  wire logic              q_pop
);

  hte_pkg::hte_item_t fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  hte_pkg::hte_item_t cls;

  always_comb begin
    cls.kind   = in_req_type;
    cls.col    = in_column_index;
    cls.vec[0] = in_x;
    cls.vec[1] = in_y;
    cls.vec[2] = in_z;
    cls.vec[3] = in_w;
    if (in_req_type == hte_pkg::REQ_POSITION) begin
      cls.vec[3] = 32'(64'd1 << FRAC_BITS);
    end else if (in_req_type == hte_pkg::REQ_VECTOR) begin
      cls.vec[3] = '0;
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  // unused code: take the beat, queue nothing
  assign push     = in_valid && in_ready && (in_req_type != hte_pkg::REQ_UNUSED);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = 2'(cnt_r + {1'b0, push} - {1'b0, q_pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hte_back.sv =====
// ----------------------------------------------------------------------------
// hte_back
// Holds the matrix and runs the matrix-vector datapath: one stage of sixteen
// multipliers, one stage of pair sums, then the final sum with rounding and
// saturation feeding the result register or the matrix write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module hte_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire hte_pkg::hte_item_t q_item,
  output      logic               q_pop,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [31:0] out_x,
  output      logic signed [31:0] out_y,
  output      logic signed [31:0] out_z,
  output      logic signed [31:0] out_w
);

  localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [65:0] HALF_FX = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] SAT_HI  = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO  = -66'sd2147483648;

  logic [15:0][31:0] mtx_r, mtx_nxt;
  logic [31:0]       stage_r [12];

  logic                   s1_v_r, s2_v_r;
  logic [2:0]             s1_kind_r, s2_kind_r;
  logic [1:0]             s1_col_r, s2_col_r;
  logic signed [63:0]     prod_r [4][4];
  logic signed [64:0]     psum_r [4][2];

  logic                   out_valid_r;
  logic [3:0][31:0]       out_r;

  logic                   en, block, issue, needs_mult;
  logic signed [31:0]     opa [4][4];
  logic signed [31:0]     opb [4];
  logic signed [65:0]     tot [4];
  logic signed [65:0]     shv [4];
  logic [3:0][31:0]       res;

  assign en    = !out_valid_r || out_ready;
  // hold issue while a matrix-rewriting op is still in the pipe
  assign block = (s1_v_r && ((s1_kind_r == hte_pkg::REQ_INVERSE) ||
                             (s1_kind_r == hte_pkg::REQ_APPEND && s1_col_r == 2'd3))) ||
                 (s2_v_r && ((s2_kind_r == hte_pkg::REQ_INVERSE) ||
                             (s2_kind_r == hte_pkg::REQ_APPEND && s2_col_r == 2'd3)));
  assign issue = q_valid && en && !block;
  assign q_pop = issue;
  assign needs_mult = (q_item.kind == hte_pkg::REQ_APPEND)   ||
                      (q_item.kind == hte_pkg::REQ_HOMOG)    ||
                      (q_item.kind == hte_pkg::REQ_POSITION) ||
                      (q_item.kind == hte_pkg::REQ_VECTOR)   ||
                      (q_item.kind == hte_pkg::REQ_INVERSE);

  // operand select: inverse uses the transposed 3x3 rows against the translation
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (q_item.kind == hte_pkg::REQ_INVERSE) begin
          opa[r][c] = (c < 3) ? $signed(mtx_r[r*4+c]) : 32'sd0;
        end else begin
          opa[r][c] = $signed(mtx_r[c*4+r]);
        end
      end
    end
    for (int c = 0; c < 4; c++) begin
      if (q_item.kind == hte_pkg::REQ_INVERSE) begin
        opb[c] = (c < 3) ? $signed(mtx_r[12+c]) : 32'sd0;
      end else begin
        opb[c] = $signed(q_item.vec[c]);
      end
    end
  end

  // final sum, round half up, saturate
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      tot[r] = 66'(psum_r[r][0]) + 66'(psum_r[r][1]) + HALF_FX;
      shv[r] = tot[r] >>> FRAC_BITS;
      if (shv[r] > SAT_HI) begin
        res[r] = 32'h7fff_ffff;
      end else if (shv[r] < SAT_LO) begin
        res[r] = 32'h8000_0000;
      end else begin
        res[r] = shv[r][31:0];
      end
    end
  end

  always_comb begin
    mtx_nxt = mtx_r;
    if (issue && q_item.kind == hte_pkg::REQ_LOAD) begin
      for (int r = 0; r < 4; r++) begin
        mtx_nxt[{q_item.col, 2'(r)}] = q_item.vec[r];
      end
    end else if (issue && q_item.kind == hte_pkg::REQ_TRANSPOSE) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          mtx_nxt[c*4+r] = mtx_r[r*4+c];
        end
      end
    end
    if (en && s2_v_r && s2_kind_r == hte_pkg::REQ_APPEND && s2_col_r == 2'd3) begin
      for (int i = 0; i < 12; i++) begin
        mtx_nxt[i] = stage_r[i];
      end
      for (int r = 0; r < 4; r++) begin
        mtx_nxt[12+r] = res[r];
      end
    end else if (en && s2_v_r && s2_kind_r == hte_pkg::REQ_INVERSE) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          mtx_nxt[c*4+r] = mtx_r[r*4+c];
        end
      end
      for (int r = 0; r < 3; r++) begin
        mtx_nxt[12+r] = (res[r] == 32'h8000_0000) ? 32'h7fff_ffff : 32'(-$signed(res[r]));
      end
      mtx_nxt[3]  = '0;
      mtx_nxt[7]  = '0;
      mtx_nxt[11] = '0;
      mtx_nxt[15] = ONE_FX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        mtx_r[i] <= (i % 5 == 0) ? ONE_FX : '0;
      end
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mtx_r <= mtx_nxt;
      if (en) begin
        s1_v_r      <= issue && needs_mult;
        s2_v_r      <= s1_v_r;
        out_valid_r <= s2_v_r && ((s2_kind_r == hte_pkg::REQ_HOMOG) ||
                                  (s2_kind_r == hte_pkg::REQ_POSITION) ||
                                  (s2_kind_r == hte_pkg::REQ_VECTOR));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r <= q_item.kind;
      s1_col_r  <= q_item.col;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_r[r][c] <= opa[r][c] * opb[c];
        end
      end
      s2_kind_r <= s1_kind_r;
      s2_col_r  <= s1_col_r;
      for (int r = 0; r < 4; r++) begin
        psum_r[r][0] <= 65'(prod_r[r][0]) + 65'(prod_r[r][1]);
        psum_r[r][1] <= 65'(prod_r[r][2]) + 65'(prod_r[r][3]);
      end
      if (s2_v_r && s2_kind_r == hte_pkg::REQ_APPEND && s2_col_r != 2'd3) begin
        for (int r = 0; r < 4; r++) begin
          stage_r[{s2_col_r, 2'(r)}] <= res[r];
        end
      end
      if (s2_v_r) begin
        out_r[0] <= res[0];
        out_r[1] <= res[1];
        out_r[2] <= res[2];
        out_r[3] <= (s2_kind_r == hte_pkg::REQ_HOMOG) ? res[3] : '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = $signed(out_r[0]);
  assign out_y     = $signed(out_r[1]);
  assign out_z     = $signed(out_r[2]);
  assign out_w     = $signed(out_r[3]);

endmodule

`default_nettype wire

// ===== hw/rtl/homogeneous_transform_engine_unit.sv =====
// ----------------------------------------------------------------------------
// homogeneous_transform_engine_unit
// 4x4 column-major Q16.16 transform matrix with load, append, point
// transform, transpose and rigid inverse requests.
//
//   channel | direction | ports
//   --------+-----------+------------------------------------------------
//   in      | input     | in_valid/in_ready, in_req_type, in_column_index,
//           |           | in_x, in_y, in_z, in_w
//   out     | output    | out_valid/out_ready, out_x, out_y, out_z, out_w
//
// One beat per cycle sustained for load, transform and transpose while not stalled.
// A transform result passes the product, pair-sum and output registers in turn.
// Append of column 3 and inverse rewrite the matrix from the multiplier
// pipeline, so the next item waits while they are in the pipe.
// Reset loads the identity matrix and empties the queue and pipeline.
// A stalled out beat freezes the pipeline; the two-entry queue fills meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_transform_engine_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [2:0]         in_req_type,
  input  wire logic [1:0]         in_column_index,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_y,
  input  wire logic signed [31:0] in_z,
  input  wire logic signed [31:0] in_w,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [31:0] out_x,
  output      logic signed [31:0] out_y,
  output      logic signed [31:0] out_z,
  output      logic signed [31:0] out_w
);

  logic               q_valid;
  logic               q_pop;
  hte_pkg::hte_item_t q_item;

  hte_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_column_index (in_column_index),
    .in_x            (in_x),
    .in_y            (in_y),
    .in_z            (in_z),
    .in_w            (in_w),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  hte_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_w     (out_w)
  );

endmodule

`default_nettype wire
